// ===== sv/met_pkg.sv =====
// ----------------------------------------------------------------------------
// met_pkg
// Shared widths, register map, quadrant codes and trace phase type for the
// midpoint ellipse tracer.
// ----------------------------------------------------------------------------
package met_pkg;

    // configuration field widths
    localparam int CENTER_W   = 12;
    localparam int CFG_AXIS_W = 10;

    // result field widths
    localparam int PIX_W      = 13;
    localparam int QUAD_W     = 2;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // stream payload widths
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 32;
    localparam int M_USER_W   = 3;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_SEMI_A   = 2'd2;
    localparam logic [1:0] REG_SEMI_B   = 2'd3;

    // mirror order of the four pixels of one step
    localparam logic [QUAD_W-1:0] Q_PXPY = 2'd0;
    localparam logic [QUAD_W-1:0] Q_MXPY = 2'd1;
    localparam logic [QUAD_W-1:0] Q_MXMY = 2'd2;
    localparam logic [QUAD_W-1:0] Q_PXMY = 2'd3;

    // trace phase
    typedef enum logic [1:0] {
        PH_DONE = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } phase_t;

endpackage

// ===== sv/midpoint_ellipse_tracer_unit.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_tracer_unit
// Midpoint ellipse rasteriser: each step request yields the four mirrored
// pixels of the next point of the first quadrant.
// ----------------------------------------------------------------------------
// A request with restart set starts the trace at (0, b); any other request
// moves on one point. Each point gives four pixels in the order +x+y, -x+y,
// -x-y, +x-y, the fourth with tlast, and all four of the final point with
// curve_done set. Once the ellipse is finished, requests are taken and give
// nothing. One request is handled at a time; tready is low until its pixels
// have all left. With no back-pressure an ordinary step passes the accepting
// state, the point check, decision updates ST_ADV1 to ST_ADV3, the region
// check and then gives one pixel per cycle. A restart adds ST_R_MUL, ST_R_SEED
// and a region check, the first request after a semi-axis write adds ST_SQ_A
// to ST_SQ_C (both squares go through the one shared multiplier) and the
// change to region two adds ST_S2_A to ST_S2_F (multiplier work) and a second
// region check, once per ellipse. After the end only the point check runs.
module midpoint_ellipse_tracer_unit
    import met_pkg::*;
#(
    parameter int AXIS_BITS = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // apb configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // step requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] restart, rest zero
    // pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [12:0] pixel_x, [25:13] pixel_y, rest zero
    output logic                  m_tlast,
    output logic [M_USER_W-1:0]   m_tuser    // [1:0] quadrant, [2] curve_done
);

    // effective semi-axis width and derived datapath widths
    localparam int AB  = (AXIS_BITS < CFG_AXIS_W) ? AXIS_BITS : CFG_AXIS_W;
    localparam int XW  = AB + 2;          // step x, unsigned
    localparam int YW  = AB + 2;          // step y, signed
    localparam int SQW = 2 * AB;          // a^2, b^2
    localparam int SW  = 3 * AB + 4;      // slope terms, signed
    localparam int TRW = SW + 2;          // decision increment, signed
    localparam int DW  = 4 * AB + 8;      // scaled decision, two's complement
    localparam int MW  = 2 * AB + 6;      // multiplier operand
    localparam int PW  = 2 * MW;          // multiplier product

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_R_MUL,
        ST_R_SEED,
        ST_CHECK,
        ST_ADV1,
        ST_ADV2,
        ST_ADV3,
        ST_SETTLE,
        ST_S2_A,
        ST_S2_B,
        ST_S2_C,
        ST_S2_D,
        ST_S2_E,
        ST_S2_F,
        ST_EMIT
    } state_t;

    // which terms the decision increment takes
    typedef struct packed {
        logic use_sx;
        logic use_sy;
        logic use_aa;
    } term_sel_t;

    // control state
    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic                   squares_ok_reg, squares_ok_next;
    logic                   restart_reg, restart_next;
    logic                   advanced_reg, advanced_next;
    logic [QUAD_W-1:0]      quad_reg, quad_next;
    term_sel_t              term_sel_reg, term_sel_next;

    // configuration
    logic [CENTER_W-1:0]    center_x_reg, center_x_next;
    logic [CENTER_W-1:0]    center_y_reg, center_y_next;
    logic [CFG_AXIS_W-1:0]  semi_a_reg, semi_a_next;
    logic [CFG_AXIS_W-1:0]  semi_b_reg, semi_b_next;

    // datapath
    logic [SQW-1:0]         aa_reg, aa_next;
    logic [SQW-1:0]         bb_reg, bb_next;
    logic [XW-1:0]          x_reg, x_next;
    logic signed [YW-1:0]   y_reg, y_next;
    logic signed [SW-1:0]   sx_reg, sx_next;
    logic signed [SW-1:0]   sy_reg, sy_next;
    logic [DW-1:0]          dec_reg, dec_next;
    logic signed [TRW-1:0]  term_reg, term_next;
    logic [PW-1:0]          prod_reg;
    logic [XW-1:0]          px_reg, px_next;
    logic signed [YW-1:0]   py_reg, py_next;

    logic [AB-1:0]          a_eff;
    logic [AB-1:0]          b_eff;
    logic [MW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    logic [PW-1:0]          prod_w;
    logic signed [YW:0]     ym1_w;
    logic [YW:0]            ym1_abs_w;
    logic signed [SW-1:0]   aa2_w;
    logic signed [SW-1:0]   bb2_w;
    logic                   dec_neg;
    logic                   dec_pos;
    logic [DW-1:0]          dterm_w;
    logic                   cfg_wr;
    logic signed [PIX_W-1:0] cx_w, cy_w, ox_w, oy_w;
    logic [PIX_W-1:0]       pix_x_w, pix_y_w;

    assign a_eff     = semi_a_reg[AB-1:0];
    assign b_eff     = semi_b_reg[AB-1:0];
    assign aa2_w     = SW'({aa_reg, 1'b0});
    assign bb2_w     = SW'({bb_reg, 1'b0});
    assign dec_neg   = dec_reg[DW-1];
    assign dec_pos   = !dec_neg && (dec_reg != '0);
    assign ym1_w     = $signed({y_reg[YW-1], y_reg}) - (YW+1)'(1);
    assign ym1_abs_w = ym1_w[YW] ? (YW+1)'(-ym1_w) : (YW+1)'(ym1_w);
    assign dterm_w   = DW'(term_reg);
    assign cfg_wr    = psel && penable && pwrite && pready;

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_A: begin
                mul_a = MW'(a_eff);
                mul_b = MW'(a_eff);
            end
            ST_SQ_B: begin
                mul_a = MW'(b_eff);
                mul_b = MW'(b_eff);
            end
            ST_R_MUL: begin
                mul_a = MW'(aa_reg);
                mul_b = MW'(b_eff);
            end
            ST_S2_A: begin
                mul_a = MW'({x_reg, 1'b1});
                mul_b = MW'({x_reg, 1'b1});
            end
            ST_S2_B: begin
                mul_a = MW'(bb_reg);
                mul_b = prod_reg[MW-1:0];
            end
            ST_S2_C: begin
                mul_a = MW'(ym1_abs_w);
                mul_b = MW'(ym1_abs_w);
            end
            ST_S2_D: begin
                mul_a = MW'(aa_reg);
                mul_b = prod_reg[MW-1:0];
            end
            ST_S2_E: begin
                mul_a = MW'(aa_reg);
                mul_b = MW'(bb_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w = PW'(mul_a) * PW'(mul_b);

    // sequencer and datapath next values
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        squares_ok_next = squares_ok_reg;
        restart_next    = restart_reg;
        advanced_next   = advanced_reg;
        quad_next       = quad_reg;
        term_sel_next   = term_sel_reg;
        aa_next         = aa_reg;
        bb_next         = bb_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        dec_next        = dec_reg;
        term_next       = term_reg;
        px_next         = px_reg;
        py_next         = py_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    restart_next  = s_tdata[0];
                    advanced_next = 1'b0;
                    if (!squares_ok_reg) begin
                        state_next = ST_SQ_A;
                    end else if (s_tdata[0]) begin
                        state_next = ST_R_MUL;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SQ_A: begin
                state_next = ST_SQ_B;
            end
            ST_SQ_B: begin
                aa_next    = prod_reg[SQW-1:0];
                state_next = ST_SQ_C;
            end
            ST_SQ_C: begin
                bb_next         = prod_reg[SQW-1:0];
                squares_ok_next = 1'b1;
                state_next      = restart_reg ? ST_R_MUL : ST_CHECK;
            end
            // restart: point (0, b), slopes 0 and 2a^2b
            ST_R_MUL: begin
                x_next     = '0;
                y_next     = YW'(b_eff);
                sx_next    = '0;
                state_next = ST_R_SEED;
            end
            ST_R_SEED: begin
                sy_next    = {prod_reg[SW-2:0], 1'b0};
                dec_next   = DW'({bb_reg, 2'b00}) - {prod_reg[DW-3:0], 2'b00}
                             + DW'(aa_reg);
                phase_next = PH_ONE;
                state_next = ST_SETTLE;
            end
            // latch the point to plot, or drop the request when finished
            ST_CHECK: begin
                if (phase_reg == PH_DONE) begin
                    state_next = ST_IDLE;
                end else begin
                    px_next    = x_reg;
                    py_next    = y_reg;
                    quad_next  = Q_PXPY;
                    state_next = ST_ADV1;
                end
            end
            // move the point and slopes, pick the decision increment
            ST_ADV1: begin
                if (phase_reg == PH_ONE) begin
                    x_next  = x_reg + XW'(1);
                    sx_next = sx_reg + bb2_w;
                    if (!dec_neg) begin
                        y_next  = y_reg - YW'(1);
                        sy_next = sy_reg - aa2_w;
                    end
                    term_sel_next = '{use_sx: 1'b1, use_sy: !dec_neg, use_aa: 1'b0};
                end else begin
                    y_next  = y_reg - YW'(1);
                    sy_next = sy_reg - aa2_w;
                    if (dec_pos) begin
                        term_sel_next = '{use_sx: 1'b0, use_sy: 1'b1, use_aa: 1'b1};
                    end else begin
                        x_next        = x_reg + XW'(1);
                        sx_next       = sx_reg + bb2_w;
                        term_sel_next = '{use_sx: 1'b1, use_sy: 1'b1, use_aa: 1'b1};
                    end
                end
                state_next = ST_ADV2;
            end
            ST_ADV2: begin
                term_next = (term_sel_reg.use_sx ? TRW'(sx_reg) : TRW'(0))
                          - (term_sel_reg.use_sy ? TRW'(sy_reg) : TRW'(0))
                          + (term_sel_reg.use_aa ? TRW'($signed({1'b0, aa_reg}))
                                                 : TRW'($signed({1'b0, bb_reg})));
                state_next = ST_ADV3;
            end
            ST_ADV3: begin
                dec_next      = dec_reg + {dterm_w[DW-3:0], 2'b00};
                advanced_next = 1'b1;
                state_next    = ST_SETTLE;
            end
            // region change or end of trace
            ST_SETTLE: begin
                if (phase_reg == PH_ONE && !(sx_reg < sy_reg)) begin
                    state_next = ST_S2_A;
                end else begin
                    if (phase_reg == PH_TWO && y_reg[YW-1]) begin
                        phase_next = PH_DONE;
                    end
                    state_next = advanced_reg ? ST_EMIT : ST_CHECK;
                end
            end
            // region two seed: b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2
            ST_S2_A: begin
                state_next = ST_S2_B;
            end
            ST_S2_B: begin
                state_next = ST_S2_C;
            end
            ST_S2_C: begin
                dec_next   = prod_reg[DW-1:0];
                state_next = ST_S2_D;
            end
            ST_S2_D: begin
                state_next = ST_S2_E;
            end
            ST_S2_E: begin
                dec_next   = dec_reg + {prod_reg[DW-3:0], 2'b00};
                state_next = ST_S2_F;
            end
            ST_S2_F: begin
                dec_next   = dec_reg - {prod_reg[DW-3:0], 2'b00};
                phase_next = PH_TWO;
                state_next = ST_SETTLE;
            end
            // four mirrored pixels, one per cycle while m_tready is high
            ST_EMIT: begin
                if (m_tready) begin
                    quad_next = quad_reg + QUAD_W'(1);
                    if (quad_reg == Q_PXMY) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_comb begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        semi_a_next   = semi_a_reg;
        semi_b_next   = semi_b_reg;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_CENTER_X: center_x_next = pwdata[CENTER_W-1:0];
                REG_CENTER_Y: center_y_next = pwdata[CENTER_W-1:0];
                REG_SEMI_A:   semi_a_next   = pwdata[CFG_AXIS_W-1:0];
                REG_SEMI_B:   semi_b_next   = pwdata[CFG_AXIS_W-1:0];
                default:      center_x_next = center_x_reg;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = APB_DATA_W'(center_x_reg);
            REG_CENTER_Y: prdata = APB_DATA_W'(center_y_reg);
            REG_SEMI_A:   prdata = APB_DATA_W'(semi_a_reg);
            REG_SEMI_B:   prdata = APB_DATA_W'(semi_b_reg);
            default:      prdata = '0;
        endcase
    end

    // state and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_DONE;
            squares_ok_reg <= 1'b0;
            restart_reg    <= 1'b0;
            advanced_reg   <= 1'b0;
            quad_reg       <= Q_PXPY;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            semi_a_reg     <= '0;
            semi_b_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            restart_reg    <= restart_next;
            advanced_reg   <= advanced_next;
            quad_reg       <= quad_next;
            center_x_reg   <= center_x_next;
            center_y_reg   <= center_y_next;
            semi_a_reg     <= semi_a_next;
            semi_b_reg     <= semi_b_next;
            // a new semi-axis makes the stored squares stale
            if (cfg_wr && (paddr[3:2] == REG_SEMI_A || paddr[3:2] == REG_SEMI_B)) begin
                squares_ok_reg <= 1'b0;
            end else begin
                squares_ok_reg <= squares_ok_next;
            end
        end
        term_sel_reg <= term_sel_next;
        aa_reg       <= aa_next;
        bb_reg       <= bb_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        dec_reg      <= dec_next;
        term_reg     <= term_next;
        prod_reg     <= prod_w;
        px_reg       <= px_next;
        py_reg       <= py_next;
    end

    // pixel coordinates, wrapped to the pixel width
    assign cx_w    = PIX_W'($signed(center_x_reg));
    assign cy_w    = PIX_W'($signed(center_y_reg));
    assign ox_w    = $signed(PIX_W'(px_reg));
    assign oy_w    = PIX_W'(py_reg);
    assign pix_x_w = (quad_reg == Q_PXPY || quad_reg == Q_PXMY) ? PIX_W'(cx_w + ox_w)
                                                                 : PIX_W'(cx_w - ox_w);
    assign pix_y_w = (quad_reg == Q_PXPY || quad_reg == Q_MXPY) ? PIX_W'(cy_w + oy_w)
                                                                 : PIX_W'(cy_w - oy_w);

    // ports
    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = M_DATA_W'({pix_y_w, pix_x_w});
    assign m_tlast  = (quad_reg == Q_PXMY);
    assign m_tuser  = {(phase_reg == PH_DONE), quad_reg};

`ifndef NO_ASSERTIONS
    // a request is never taken while pixels are on offer
    a_busy_excl : assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request accepted while pixels pending");

    // after a request is taken the tracer is busy
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("tracer ready directly after a request");

    // pixels of one step come in mirror order
    a_quad_order : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1))
        else $error("pixel mirror order broken");

    // curve_done is the same on all pixels of a step
    a_done_steady : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tuser[2] == $past(m_tuser[2]))
        else $error("curve_done changed within a step");

    // the last pixel hands control back to the request side
    a_ready_after_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready)
        else $error("tracer not ready after last pixel");
`endif

endmodule
